>>> src/lds_pkg.sv
package lds_pkg;

    localparam int MaxVertices = 64;
    localparam int Symbols     = 64;
    localparam int MaxSucc     = 4;
    localparam int VertW       = 6;
    localparam int CntW        = 7;
    localparam int SuccCntW    = 3;

    typedef logic [VertW-1:0]   t_vert;
    typedef logic [Symbols-1:0] t_set;

    typedef struct packed {
        t_vert               vertex;
        t_set                use_set;
        t_set                def_set;
        logic [SuccCntW-1:0] succ_count;
        t_vert               succ_a;
        t_vert               succ_b;
        t_vert               succ_c;
        t_vert               succ_d;
        logic                last_vertex;
    } t_in_item;

    typedef struct packed {
        t_vert out_vertex;
        t_set  live_in;
        t_set  live_out;
        logic  final_result;
    } t_out_item;

    typedef struct packed {
        logic [SuccCntW-1:0] num;
        t_vert               s0;
        t_vert               s1;
        t_vert               s2;
        t_vert               s3;
    } t_succ_rec;

    typedef struct packed {
        t_set                use_set;
        t_set                def_set;
        logic [SuccCntW-1:0] succ_num;
    } t_vrec;

endpackage

>>> src/liveness_dataflow_solver_unit.sv
// Channel | Dir | Handshake                 | Payload
// input   | in  | i_in_valid / o_in_stall   | i_in_item  (lds_pkg::t_in_item)
// output  | out | o_out_valid / i_out_stall | o_out_item (lds_pkg::t_out_item)
// config  | in  | i_cfg_we                  | i_cfg_data (num_vertices)
// The last load starts the solve: the in sets of vertices 0 to n-1 are cleared, then sweeps
// run from vertex n-1 down to 0, each vertex in order: record and old in read, four successor
// in reads through one port, update; they repeat until a sweep changes no in set, at most
// n + 1 sweeps. Results then leave from vertex 0 up, each held while the output stalls.
// o_in_stall is high from the last load until the final result is registered.
// Reset is synchronous, active low; it clears the vertex valid bits, so the vertex store reads empty.
module liveness_dataflow_solver_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lds_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lds_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data
);
    import lds_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_V_RD, S_V_WAIT, S_SUCC_RD, S_SUCC_ACC, S_UPDATE,
        S_OUT_RD, S_OUT_HOLD
    } t_state;

    t_state                 r_state;
    logic [CntW-1:0]        r_num;
    logic [CntW-1:0]        r_n;
    t_vert                  r_idx;
    logic [1:0]             r_k;
    logic [MaxVertices-1:0] r_loaded;
    t_set                   r_acc;
    t_set                   r_old;
    logic                   r_acc_en;
    logic                   r_changed;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic      vm_we;
    t_vrec     vm_wdata;
    t_succ_rec vm_wsucc;
    t_vrec     vm_rdata;
    t_succ_rec vm_rsucc;
    logic      in_we;
    t_set      in_wdata;
    t_vert     in_raddr;
    t_set      in_rdata;
    logic      out_we;
    t_set      out_rdata;

    t_vrec     rec;
    t_succ_rec srec;
    t_vert     sel_succ;
    t_set      nin;
    logic [SuccCntW-1:0] in_cnt;
    logic [CntW-1:0] lim_n;
    logic      at_last;
    logic      in_changed;
    logic      out_load;

    lds_vertex_mem u_vmem (
        .i_clk, .i_we(vm_we), .i_waddr(i_in_item.vertex), .i_wdata(vm_wdata),
        .i_wsucc(vm_wsucc), .i_raddr(r_idx), .o_rdata(vm_rdata), .o_rsucc(vm_rsucc)
    );
    lds_set_mem u_inmem (
        .i_clk, .i_we(in_we), .i_waddr(r_idx), .i_wdata(in_wdata),
        .i_raddr(in_raddr), .o_rdata(in_rdata)
    );
    lds_set_mem u_outmem (
        .i_clk, .i_we(out_we), .i_waddr(r_idx), .i_wdata(r_acc),
        .i_raddr(r_idx), .o_rdata(out_rdata)
    );

    assign in_cnt = (i_in_item.succ_count > SuccCntW'(MaxSucc))
                    ? SuccCntW'(MaxSucc) : i_in_item.succ_count;
    assign vm_we    = (r_state == S_LOAD) && i_in_valid;
    assign vm_wdata = '{use_set: i_in_item.use_set, def_set: i_in_item.def_set,
                        succ_num: in_cnt};
    assign vm_wsucc = '{num: in_cnt,
                        s0: (in_cnt > 3'd0) ? i_in_item.succ_a : '0,
                        s1: (in_cnt > 3'd1) ? i_in_item.succ_b : '0,
                        s2: (in_cnt > 3'd2) ? i_in_item.succ_c : '0,
                        s3: (in_cnt > 3'd3) ? i_in_item.succ_d : '0};

    assign rec  = r_loaded[r_idx] ? vm_rdata : '0;
    assign srec = r_loaded[r_idx] ? vm_rsucc : '0;
    always_comb begin
        unique case (r_k)
            2'd0:    sel_succ = srec.s0;
            2'd1:    sel_succ = srec.s1;
            2'd2:    sel_succ = srec.s2;
            default: sel_succ = srec.s3;
        endcase
    end

    assign lim_n      = (r_num == '0) ? CntW'(1)
                      : (r_num > CntW'(MaxVertices)) ? CntW'(MaxVertices) : r_num;
    assign at_last    = ({1'b0, r_idx} == r_n - CntW'(1));
    assign nin        = rec.use_set | (r_acc & ~rec.def_set);
    assign in_changed = (nin != r_old);

    assign in_raddr = (r_state == S_SUCC_RD) ? sel_succ : r_idx;
    assign in_we    = (r_state == S_CLEAR) || (r_state == S_UPDATE);
    assign in_wdata = (r_state == S_CLEAR) ? '0 : nin;
    assign out_we   = (r_state == S_UPDATE);
    assign out_load = (r_state == S_OUT_HOLD) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_num       <= CntW'(MaxVertices);
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        r_loaded[i_in_item.vertex] <= 1'b1;
                        if (i_in_item.last_vertex) begin
                            r_n     <= lim_n;
                            r_idx   <= '0;
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    if (at_last) begin
                        r_changed <= 1'b0;
                        r_state   <= S_V_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_V_RD: r_state <= S_V_WAIT;
                S_V_WAIT: begin
                    r_old   <= in_rdata;
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_state <= S_SUCC_RD;
                end
                S_SUCC_RD: begin
                    r_acc_en <= ({1'b0, r_k} < srec.num) && ({1'b0, sel_succ} < r_n);
                    r_state  <= S_SUCC_ACC;
                end
                S_SUCC_ACC: begin
                    if (r_acc_en) begin
                        r_acc <= r_acc | in_rdata;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_state <= S_SUCC_RD;
                    end
                end
                S_UPDATE: begin
                    if (r_idx == '0) begin
                        if (r_changed || in_changed) begin
                            r_changed <= 1'b0;
                            r_idx     <= VertW'(r_n - CntW'(1));
                            r_state   <= S_V_RD;
                        end else begin
                            r_state <= S_OUT_RD;
                        end
                    end else begin
                        if (in_changed) begin
                            r_changed <= 1'b1;
                        end
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_V_RD;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_HOLD;
                S_OUT_HOLD: begin
                    if (out_load) begin
                        r_out.out_vertex   <= r_idx;
                        r_out.live_in      <= in_rdata;
                        r_out.live_out     <= out_rdata;
                        r_out.final_result <= at_last;
                        if (at_last) begin
                            r_loaded <= '0;
                            r_state  <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("output changed while stalled");
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> o_in_stall)
        else $error("input taken while busy");
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> (r_n != '0) && (r_n <= CntW'(MaxVertices)))
        else $error("vertex count out of range");

endmodule

>>> src/lds_vertex_mem.sv
module lds_vertex_mem (
    input  logic               i_clk,
    input  logic               i_we,
    input  lds_pkg::t_vert     i_waddr,
    input  lds_pkg::t_vrec     i_wdata,
    input  lds_pkg::t_succ_rec i_wsucc,
    input  lds_pkg::t_vert     i_raddr,
    output lds_pkg::t_vrec     o_rdata,
    output lds_pkg::t_succ_rec o_rsucc
);
    import lds_pkg::*;

    t_vrec     r_mem  [MaxVertices];
    t_succ_rec r_smem [MaxVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr]  <= i_wdata;
            r_smem[i_waddr] <= i_wsucc;
        end
        o_rdata <= r_mem[i_raddr];
        o_rsucc <= r_smem[i_raddr];
    end

endmodule

>>> src/lds_set_mem.sv
module lds_set_mem (
    input  logic           i_clk,
    input  logic           i_we,
    input  lds_pkg::t_vert i_waddr,
    input  lds_pkg::t_set  i_wdata,
    input  lds_pkg::t_vert i_raddr,
    output lds_pkg::t_set  o_rdata
);
    import lds_pkg::*;

    t_set r_mem [MaxVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
